### rtl/assert_macros.svh
// assertion macros used by the indexed_list_engine rtl
// depends on nothing; clk and rst_n are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// concurrent check on a named clock and active-low reset
`define ASSERT_ON_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);
// concurrent check on the module clock clk and reset rst_n
`define ASSERT_CHK(label, prop, msg) \
    `ASSERT_ON_CLK(label, clk, rst_n, prop, msg)
`else
`define ASSERT_ON_CLK(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_CHK(label, prop, msg)
`endif
`endif

### rtl/ile_pkg.sv
// shared types and constants of the indexed list engine
// depends on nothing
`timescale 1ns / 1ps

package ile_pkg;

    localparam int FIELD_W = 8;
    localparam int IDX_W   = 7;

    // operation codes of an input beat
    typedef enum logic [1:0]
    {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // one stored record
    typedef struct packed
    {
        logic [FIELD_W-1:0] vac;
        logic [FIELD_W-1:0] health;
    } rec_t;

    // what a cell loads into its record this cycle
    typedef enum logic [1:0]
    {
        REC_HOLD      = 2'd0,
        REC_FROM_PREV = 2'd1,
        REC_LOAD_KEY  = 2'd2,
        REC_FROM_NEXT = 2'd3
    } rec_op_t;

    // per-cell control from the sequencer
    typedef struct packed
    {
        rec_op_t rec_op;
        logic    flag_capture;
        logic    flag_shift;
        logic    in_range;
    } cell_ctrl_t;

endpackage

### rtl/ile_cell.sv
// one cell of the record chain: a record and a match flag
// depends on ile_pkg
`timescale 1ns / 1ps

module ile_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  ile_pkg::cell_ctrl_t ctrl,
    input  ile_pkg::rec_t      key,
    input  ile_pkg::rec_t      prev_rec,
    input  ile_pkg::rec_t      next_rec,
    input  logic               next_flag,
    output ile_pkg::rec_t      rec,
    output logic               flag
);

    ile_pkg::rec_t rec_reg;
    ile_pkg::rec_t rec_next;
    logic          flag_reg;
    logic          flag_next;

    // record shift, load or hold
    always_comb
    begin
        unique case (ctrl.rec_op)
            ile_pkg::REC_HOLD:      rec_next = rec_reg;
            ile_pkg::REC_FROM_PREV: rec_next = prev_rec;
            ile_pkg::REC_LOAD_KEY:  rec_next = key;
            ile_pkg::REC_FROM_NEXT: rec_next = next_rec;
            default:                rec_next = rec_reg;
        endcase
    end

    // match flag: capture a compare, or move toward the front of the chain
    always_comb
    begin
        priority if (ctrl.flag_capture)
        begin
            flag_next = ctrl.in_range && (rec_reg == key);
        end
        else if (ctrl.flag_shift)
        begin
            flag_next = next_flag;
        end
        else
        begin
            flag_next = flag_reg;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // flag register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign rec  = rec_reg;
    assign flag = flag_reg;

endmodule

### rtl/ile_back_sel.sv
// registered two-level or-tree that picks the record of the tagged back cell
// depends on ile_pkg
`timescale 1ns / 1ps

module ile_back_sel
#(
    parameter int N = 64
)
(
    input  logic          clk,
    input  ile_pkg::rec_t recs [N],
    input  logic [N-1:0]  tail,
    output ile_pkg::rec_t back
);

    localparam int GRP = 8;
    localparam int NG  = (N + GRP - 1) / GRP;

    ile_pkg::rec_t grp_reg  [NG];
    ile_pkg::rec_t grp_next [NG];
    ile_pkg::rec_t back_reg;
    ile_pkg::rec_t back_next;

    // first level: or of the tagged records within each group of eight
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < N)
                begin
                    if (tail[g * GRP + k])
                    begin
                        grp_next[g] = grp_next[g] | recs[g * GRP + k];
                    end
                end
            end
        end
    end

    // second level: or of the group results
    always_comb
    begin
        back_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            back_next = back_next | grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        back_reg <= back_next;
    end

    assign back = back_reg;

endmodule

### rtl/indexed_list_engine.sv
// indexed list engine top level: sequencer, cell chain and result register
// depends on ile_pkg, ile_cell, ile_back_sel and assert_macros.svh
//
// An ordered list of up to CAPACITY records (vac_days, health_code), kept in
// a row of cells; cell i holds record i. Each input beat (func, index,
// vac_days, health_code) is insert, remove, find or clear and gives one
// result beat (ok, found_index, count, front and back records).
// Input channel: a beat moves when item_valid is high and item_stall is low.
// item_stall is high while an item is being worked on; one item at a time.
// Insert and remove shift the chain from the given position on in the accept
// cycle, and clear only zeroes the count; the result then passes S_PIPE1 and
// S_PIPE2, which wait out the registered back-record tree, and is loaded into
// the result register in S_LOAD. Find captures a compare in every cell, then
// shifts the match flags toward cell 0 one place a cycle until a flag reaches
// cell 0 or the last list position is passed, then takes the same path to the
// result register. Items do not overlap: the next item can be taken on the
// cycle after the result is loaded.
// Output channel: result_valid holds a beat until result_stall is low; a
// stalled result is held, and a new item may be taken and worked on
// meanwhile, waiting before its load until the register is free.
// Reset empties the list and clears both channels; records need no reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_list_engine
#(
    parameter int CAPACITY = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    func,
    input  logic [ile_pkg::IDX_W-1:0]     index,
    input  logic [ile_pkg::FIELD_W-1:0]   vac_days,
    input  logic [ile_pkg::FIELD_W-1:0]   health_code,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          ok,
    output logic [ile_pkg::IDX_W-1:0]     found_index,
    output logic [ile_pkg::IDX_W-1:0]     count,
    output logic [ile_pkg::FIELD_W-1:0]   front_vac,
    output logic [ile_pkg::FIELD_W-1:0]   front_health,
    output logic [ile_pkg::FIELD_W-1:0]   back_vac,
    output logic [ile_pkg::FIELD_W-1:0]   back_health
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = ile_pkg::IDX_W;
    localparam int POS_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FIND,
        S_PIPE1,
        S_PIPE2,
        S_LOAD
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          f_cnt_reg;
    logic                      res_ok_reg;
    logic [CNT_W-1:0]          res_found_reg;
    logic                      out_valid_reg;
    logic                      out_ok_reg;
    logic [OUT_W-1:0]          out_found_reg;
    logic [OUT_W-1:0]          out_count_reg;
    ile_pkg::rec_t             out_front_reg;
    ile_pkg::rec_t             out_back_reg;

    ile_pkg::func_t            func_in;
    ile_pkg::rec_t             key;
    logic                      acc;
    logic [POS_W-1:0]          pos_w;
    logic [POS_W-1:0]          cnt_w;
    logic [POS_W-1:0]          eff_pos;
    logic                      can_insert;
    logic                      can_remove;
    logic                      find_last;
    logic                      can_load;

    ile_pkg::cell_ctrl_t       ctrl      [CAPACITY];
    ile_pkg::rec_t             cell_rec  [CAPACITY];
    logic [CAPACITY-1:0]       cell_flag;
    logic [CAPACITY-1:0]       tail;
    ile_pkg::rec_t             back_rec;

    // input decode
    assign func_in    = ile_pkg::func_t'(func);
    assign key        = '{vac: vac_days, health: health_code};
    assign item_stall = (state_reg != S_IDLE);
    assign acc        = item_valid && (state_reg == S_IDLE);
    assign pos_w      = POS_W'(index);
    assign cnt_w      = POS_W'(count_reg);
    assign eff_pos    = (pos_w > cnt_w) ? cnt_w : pos_w;
    assign can_insert = (count_reg < CNT_W'(CAPACITY));
    assign can_remove = (pos_w < cnt_w);
    assign find_last  = ((CNT_W + 1)'(f_cnt_reg) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(count_reg);
    assign can_load   = !out_valid_reg || !result_stall;

    // cell chain with per-cell control
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [POS_W-1:0] CPOS = POS_W'(i);
        ile_pkg::rec_t prev_rec;
        ile_pkg::rec_t next_rec;
        logic          next_flag;

        if (i == 0)
        begin : g_first
            assign prev_rec = key;
        end
        else
        begin : g_mid
            assign prev_rec = cell_rec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_rec  = '0;
            assign next_flag = 1'b0;
        end
        else
        begin : g_inner
            assign next_rec  = cell_rec[i+1];
            assign next_flag = cell_flag[i+1];
        end

        // back record tag
        assign tail[i] = (CNT_W'(i + 1) == count_reg);

        // control decode for this position
        always_comb
        begin
            ctrl[i]          = '0;
            ctrl[i].rec_op   = ile_pkg::REC_HOLD;
            ctrl[i].in_range = (CPOS < cnt_w);
            if (acc)
            begin
                unique case (func_in)
                    ile_pkg::FUNC_INSERT:
                    begin
                        if (can_insert)
                        begin
                            if (CPOS > eff_pos)
                            begin
                                ctrl[i].rec_op = ile_pkg::REC_FROM_PREV;
                            end
                            else if (CPOS == eff_pos)
                            begin
                                ctrl[i].rec_op = ile_pkg::REC_LOAD_KEY;
                            end
                        end
                    end
                    ile_pkg::FUNC_REMOVE:
                    begin
                        if (can_remove && (CPOS >= pos_w))
                        begin
                            ctrl[i].rec_op = ile_pkg::REC_FROM_NEXT;
                        end
                    end
                    ile_pkg::FUNC_FIND:
                    begin
                        ctrl[i].flag_capture = 1'b1;
                    end
                    ile_pkg::FUNC_CLEAR:
                    begin
                        ctrl[i].rec_op = ile_pkg::REC_HOLD;
                    end
                endcase
            end
            else if (state_reg == S_FIND)
            begin
                ctrl[i].flag_shift = 1'b1;
            end
        end

        ile_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[i]),
            .key       (key),
            .prev_rec  (prev_rec),
            .next_rec  (next_rec),
            .next_flag (next_flag),
            .rec       (cell_rec[i]),
            .flag      (cell_flag[i])
        );
    end

    // back record select through a registered or-tree
    ile_back_sel #(.N(CAPACITY)) u_back_sel
    (
        .clk  (clk),
        .recs (cell_rec),
        .tail (tail),
        .back (back_rec)
    );

    // sequencer, list count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            f_cnt_reg     <= '0;
            res_ok_reg    <= 1'b0;
            res_found_reg <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_found_reg <= '0;
            out_count_reg <= '0;
            out_front_reg <= '0;
            out_back_reg  <= '0;
        end
        else
        begin
            // result beat taken with no new load behind it
            if (out_valid_reg && !result_stall && (state_reg != S_LOAD))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        res_found_reg <= '0;
                        state_reg     <= (func_in == ile_pkg::FUNC_FIND) ? S_FIND : S_PIPE1;
                        unique case (func_in)
                            ile_pkg::FUNC_INSERT:
                            begin
                                res_ok_reg <= can_insert;
                                if (can_insert)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            ile_pkg::FUNC_REMOVE:
                            begin
                                res_ok_reg <= can_remove;
                                if (can_remove)
                                begin
                                    count_reg <= count_reg - CNT_W'(1);
                                end
                            end
                            ile_pkg::FUNC_FIND:
                            begin
                                res_ok_reg <= 1'b0;
                                f_cnt_reg  <= '0;
                            end
                            ile_pkg::FUNC_CLEAR:
                            begin
                                res_ok_reg <= 1'b1;
                                count_reg  <= '0;
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    priority if (cell_flag[0])
                    begin
                        res_ok_reg    <= 1'b1;
                        res_found_reg <= f_cnt_reg;
                        state_reg     <= S_PIPE1;
                    end
                    else if (find_last)
                    begin
                        res_ok_reg    <= 1'b0;
                        res_found_reg <= count_reg;
                        state_reg     <= S_PIPE1;
                    end
                    else
                    begin
                        f_cnt_reg <= f_cnt_reg + CNT_W'(1);
                    end
                end
                S_PIPE1:
                begin
                    state_reg <= S_PIPE2;
                end
                S_PIPE2:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ok_reg    <= res_ok_reg;
                        out_found_reg <= OUT_W'(res_found_reg);
                        out_count_reg <= OUT_W'(count_reg);
                        out_front_reg <= (count_reg != '0) ? cell_rec[0] : '0;
                        out_back_reg  <= back_rec;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign result_valid = out_valid_reg;
    assign ok           = out_ok_reg;
    assign found_index  = out_found_reg;
    assign count        = out_count_reg;
    assign front_vac    = out_front_reg.vac;
    assign front_health = out_front_reg.health;
    assign back_vac     = out_back_reg.vac;
    assign back_health  = out_back_reg.health;

    // checks
    `ASSERT_CHK(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ASSERT_CHK(a_insert_grows,
        (acc && func_in == ile_pkg::FUNC_INSERT && can_insert)
            |=> (count_reg == $past(count_reg) + CNT_W'(1)),
        "insert did not grow the list")
    `ASSERT_CHK(a_clear_empties,
        (acc && func_in == ile_pkg::FUNC_CLEAR) |=> (count_reg == '0),
        "clear left records")
    `ASSERT_CHK(a_load_waits,
        (state_reg == S_LOAD && out_valid_reg && result_stall)
            |=> (state_reg == S_LOAD && out_valid_reg),
        "result overwritten while stalled")
    `ASSERT_CHK(a_found_in_list,
        (state_reg == S_LOAD && res_ok_reg && res_found_reg != '0)
            |-> (res_found_reg < count_reg),
        "match position past the list")

endmodule

### bench/tb_top.sv
// self-checking bench for indexed_list_engine: directed and random list traffic
// depends on ile_pkg and the indexed_list_engine rtl; predicts every result beat
`timescale 1ns / 1ps

module tb_top;

    localparam int CAP         = 64;
    localparam int CALM_TAIL   = 50;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 400000;

    // list phases of the random stimulus
    typedef enum int
    {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } phase_t;

    // one input beat
    typedef struct
    {
        ile_pkg::func_t fn;
        logic [6:0]     idx;
        logic [7:0]     vac;
        logic [7:0]     health;
    } list_cmd_t;

    // one result beat
    typedef struct packed
    {
        logic       ok;
        logic [6:0] found;
        logic [6:0] cnt;
        logic [7:0] fv;
        logic [7:0] fh;
        logic [7:0] bv;
        logic [7:0] bh;
    } list_outcome_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       result_stall = 1'b0;
    logic [1:0] func         = 2'd0;
    logic [6:0] index        = 7'd0;
    logic [7:0] vac_days     = 8'd0;
    logic [7:0] health_code  = 8'd0;
    logic       item_stall;
    logic       result_valid;
    logic       ok;
    logic [6:0] found_index;
    logic [6:0] count;
    logic [7:0] front_vac;
    logic [7:0] front_health;
    logic [7:0] back_vac;
    logic [7:0] back_health;

    list_cmd_t     cmd_q[$];
    list_outcome_t outcome_q[$];

    // mirror of the list contents
    logic [7:0] mirror_vac[CAP];
    logic [7:0] mirror_health[CAP];
    int         mirror_fill = 0;

    // fill level as the stimulus plan sees it
    int plan_fill = 0;

    int   total_items  = 0;
    int   accepted     = 0;
    int   checked      = 0;
    int   errors       = 0;
    int   find_hits    = 0;
    int   refused_ins  = 0;
    int   peak_fill    = 0;
    int   cycles       = 0;
    int   send_gap     = 0;
    int   hold_gap     = 0;
    logic in_taken     = 1'b0;

    indexed_list_engine #(.CAPACITY(CAP)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .index        (index),
        .vac_days     (vac_days),
        .health_code  (health_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ok           (ok),
        .found_index  (found_index),
        .count        (count),
        .front_vac    (front_vac),
        .front_health (front_health),
        .back_vac     (back_vac),
        .back_health  (back_health)
    );

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // list behavior: apply one command to the mirror, give its result beat
    function automatic list_outcome_t list_apply(list_cmd_t c);
        list_outcome_t o;
        int            pos;
        bit            hit;
        o   = '0;
        hit = 1'b0;
        case (c.fn)
            ile_pkg::FUNC_INSERT:
            begin
                if (mirror_fill < CAP)
                begin
                    pos = (int'(c.idx) > mirror_fill) ? mirror_fill : int'(c.idx);
                    for (int i = mirror_fill; i > pos; i--)
                    begin
                        mirror_vac[i]    = mirror_vac[i-1];
                        mirror_health[i] = mirror_health[i-1];
                    end
                    mirror_vac[pos]    = c.vac;
                    mirror_health[pos] = c.health;
                    mirror_fill++;
                    o.ok = 1'b1;
                end
            end
            ile_pkg::FUNC_REMOVE:
            begin
                if (int'(c.idx) < mirror_fill)
                begin
                    for (int i = int'(c.idx); i + 1 < mirror_fill; i++)
                    begin
                        mirror_vac[i]    = mirror_vac[i+1];
                        mirror_health[i] = mirror_health[i+1];
                    end
                    mirror_fill--;
                    o.ok = 1'b1;
                end
            end
            ile_pkg::FUNC_FIND:
            begin
                o.found = mirror_fill[6:0];
                for (int i = 0; i < mirror_fill; i++)
                begin
                    if (!hit && mirror_vac[i] == c.vac && mirror_health[i] == c.health)
                    begin
                        o.found = i[6:0];
                        o.ok    = 1'b1;
                        hit     = 1'b1;
                    end
                end
            end
            default:
            begin
                mirror_fill = 0;
                o.ok        = 1'b1;
            end
        endcase
        o.cnt = mirror_fill[6:0];
        if (mirror_fill > 0)
        begin
            o.fv = mirror_vac[0];
            o.fh = mirror_health[0];
            o.bv = mirror_vac[mirror_fill-1];
            o.bh = mirror_health[mirror_fill-1];
        end
        return o;
    endfunction

    // queue one command and track the planned fill level
    task automatic add_cmd(ile_pkg::func_t fn, int idx, int v, int h);
        list_cmd_t c;
        c.fn     = fn;
        c.idx    = idx[6:0];
        c.vac    = v[7:0];
        c.health = h[7:0];
        cmd_q.insert(cmd_q.size(), c);
        case (fn)
            ile_pkg::FUNC_INSERT: if (plan_fill < CAP) plan_fill++;
            ile_pkg::FUNC_REMOVE: if (idx < plan_fill) plan_fill--;
            ile_pkg::FUNC_CLEAR:  plan_fill = 0;
            default: ;
        endcase
    endtask

    // field value: often from a tiny pool so finds hit and duplicates occur
    function automatic int pick_field();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 3);
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_insert_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 0;
        if (r < 50)
            return plan_fill;
        if (r < 60)
            return CAP;
        return $urandom_range(0, CAP);
    endfunction

    function automatic int pick_remove_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && plan_fill > 0)
            return $urandom_range(0, plan_fill - 1);
        if (r < 80)
            return CAP;
        return $urandom_range(0, CAP);
    endfunction

    // one random command, weighted by the list phase
    task automatic add_random_cmd(phase_t ph);
        int r;
        int ins_w;
        int rem_w;
        int fnd_w;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  begin ins_w = 80; rem_w = 5;  fnd_w = 15; end
            PH_DRAIN: begin ins_w = 8;  rem_w = 80; fnd_w = 12; end
            default:  begin ins_w = 35; rem_w = 30; fnd_w = 32; end
        endcase
        if (r < ins_w)
            add_cmd(ile_pkg::FUNC_INSERT, pick_insert_index(), pick_field(), pick_field());
        else if (r < ins_w + rem_w)
            add_cmd(ile_pkg::FUNC_REMOVE, pick_remove_index(), pick_field(), pick_field());
        else if (r < ins_w + rem_w + fnd_w)
            add_cmd(ile_pkg::FUNC_FIND, $urandom_range(0, CAP), pick_field(), pick_field());
        else
            add_cmd(ile_pkg::FUNC_CLEAR, $urandom_range(0, CAP), pick_field(), pick_field());
    endtask

    // fill up to capacity, then push a few refused inserts
    task automatic plan_fill_up();
        while (plan_fill < CAP)
            add_random_cmd(PH_FILL);
        repeat (3)
            add_cmd(ile_pkg::FUNC_INSERT, pick_insert_index(), pick_field(), pick_field());
    endtask

    // drain to empty, then try removes on the empty list
    task automatic plan_drain();
        while (plan_fill > 0)
            add_random_cmd(PH_DRAIN);
        repeat (2)
            add_cmd(ile_pkg::FUNC_REMOVE, pick_remove_index(), pick_field(), pick_field());
    endtask

    // input driver: new beat at the falling edge once the last one is taken
    always @(negedge clk)
    begin
        list_cmd_t c;
        logic      nxt_valid;
        if (rst_n && !(item_valid && !in_taken))
        begin
            nxt_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 12) - 1;
            else if (cmd_q.size() > 0)
            begin
                c = cmd_q[0];
                cmd_q.delete(0);
                func        <= c.fn;
                index       <= c.idx;
                vac_days    <= c.vac;
                health_code <= c.health;
                nxt_valid   = 1'b1;
            end
            item_valid <= nxt_valid;
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_gap > 0)
            begin
                hold_gap--;
                result_stall <= 1'b1;
            end
            else if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                hold_gap = $urandom_range(1, 12) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge clk)
    begin
        list_cmd_t     c;
        list_outcome_t want;
        list_outcome_t got;
        if (rst_n)
        begin
            in_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                c.fn     = ile_pkg::func_t'(func);
                c.idx    = index;
                c.vac    = vac_days;
                c.health = health_code;
                want     = list_apply(c);
                outcome_q.insert(outcome_q.size(), want);
                accepted++;
                if (c.fn == ile_pkg::FUNC_FIND && want.ok)
                    find_hits++;
                if (c.fn == ile_pkg::FUNC_INSERT && !want.ok)
                    refused_ins++;
                if (mirror_fill > peak_fill)
                    peak_fill = mirror_fill;
            end
            if (result_valid && !result_stall)
            begin
                got = {ok, found_index, count, front_vac, front_health,
                       back_vac, back_health};
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result beat with nothing pending at cycle %0d", cycles);
                end
                else
                begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    checked++;
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"result %0d mismatch: ok %0d/%0d found %0d/%0d ",
                                      "count %0d/%0d front %0d,%0d/%0d,%0d ",
                                      "back %0d,%0d/%0d,%0d (expected/actual)"},
                                     checked, want.ok, got.ok, want.found, got.found,
                                     want.cnt, got.cnt, want.fv, want.fh, got.fv, got.fh,
                                     want.bv, want.bh, got.bv, got.bh);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, outcome_q.size());
            $display("[indexed_list_engine] ERROR");
            $finish;
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        // directed: empty-list corners, front/middle/back, finds, bad removes
        add_cmd(ile_pkg::FUNC_CLEAR,  0,   0,    0);
        add_cmd(ile_pkg::FUNC_REMOVE, 0,   0,    0);
        add_cmd(ile_pkg::FUNC_FIND,   0,   0,    0);
        add_cmd(ile_pkg::FUNC_INSERT, 0,   0,    0);
        add_cmd(ile_pkg::FUNC_INSERT, 64,  255,  255);
        add_cmd(ile_pkg::FUNC_INSERT, 0,   8'h80, 8'h01);
        add_cmd(ile_pkg::FUNC_INSERT, 1,   8'h01, 8'h80);
        add_cmd(ile_pkg::FUNC_INSERT, 4,   8'h55, 8'hAA);
        add_cmd(ile_pkg::FUNC_FIND,   127 & 64, 8'h80, 8'h01);
        add_cmd(ile_pkg::FUNC_FIND,   0,   8'h55, 8'hAA);
        add_cmd(ile_pkg::FUNC_FIND,   0,   8'h12, 8'h34);
        add_cmd(ile_pkg::FUNC_INSERT, 2,   0,    0);
        add_cmd(ile_pkg::FUNC_FIND,   0,   0,    0);
        add_cmd(ile_pkg::FUNC_REMOVE, 64,  0,    0);
        add_cmd(ile_pkg::FUNC_REMOVE, 6,   0,    0);
        add_cmd(ile_pkg::FUNC_REMOVE, 0,   0,    0);
        add_cmd(ile_pkg::FUNC_REMOVE, 4,   0,    0);
        add_cmd(ile_pkg::FUNC_REMOVE, 1,   0,    0);
        add_cmd(ile_pkg::FUNC_FIND,   0,   255,  255);
        add_cmd(ile_pkg::FUNC_CLEAR,  64,  255,  255);
        add_cmd(ile_pkg::FUNC_FIND,   0,   0,    0);
        add_cmd(ile_pkg::FUNC_INSERT, 5,   255,  0);
        add_cmd(ile_pkg::FUNC_REMOVE, 0,   0,    0);

        // random: full and empty excursions with mixed traffic between
        plan_fill_up();
        plan_drain();
        repeat (40)
            add_random_cmd(PH_MIX);
        plan_fill_up();
        repeat (40)
            add_random_cmd(PH_MIX);
        add_cmd(ile_pkg::FUNC_CLEAR, $urandom_range(0, CAP), pick_field(), pick_field());
        while (cmd_q.size() < 400)
            add_random_cmd(PH_MIX);
        total_items = cmd_q.size();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (accepted < total_items)
            @(posedge clk);
        while (outcome_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("list traffic: %0d commands, %0d results checked, peak fill %0d of %0d",
                 accepted, checked, peak_fill, CAP);
        $display("find hits %0d, inserts refused when full %0d, mismatches %0d",
                 find_hits, refused_ins, errors);
        if (errors == 0 && outcome_q.size() == 0)
            $display("[indexed_list_engine] OK");
        else
            $display("[indexed_list_engine] ERROR");
        $finish;
    end

endmodule
